@@ hdl/qrp_pkg.sv @@
package qrp_pkg;

  // segment mode codes (code three behaves as byte mode)
  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  // field lengths in bits
  localparam logic [3:0] NUM_TRIPLE_BITS   = 4'd10;
  localparam logic [3:0] ALNUM_PAIR_BITS   = 4'd11;
  localparam logic [3:0] ALNUM_SINGLE_BITS = 4'd6;
  localparam logic [3:0] BYTE_BITS         = 4'd8;

  localparam logic [1:0]  NUM_GROUP_SIZE = 2'd3;
  localparam logic [5:0]  ALNUM_COUNT    = 6'd45;
  localparam logic [5:0]  ALNUM_NONE     = 6'd63;
  localparam logic [14:0] TOTAL_MAX      = 15'h7FFF;
  localparam logic [3:0]  FULL_BYTE      = 4'd8;

  // one result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [3:0]  valid_bits;
    logic        bad_char;
    logic        too_long;
    logic [14:0] total_bits;
    logic        end_of_run;
  } res_t;

  // value of a character in the 45-symbol set, ALNUM_NONE if outside it
  function automatic logic [5:0] alnum_value(input logic [7:0] c);
    logic [5:0] v;
    v = ALNUM_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h37);
    end else begin
      unique case (c)
        8'h20:   v = 6'd36;
        8'h24:   v = 6'd37;
        8'h25:   v = 6'd38;
        8'h2A:   v = 6'd39;
        8'h2B:   v = 6'd40;
        8'h2D:   v = 6'd41;
        8'h2E:   v = 6'd42;
        8'h2F:   v = 6'd43;
        8'h3A:   v = 6'd44;
        default: v = ALNUM_NONE;
      endcase
    end
    return v;
  endfunction

endpackage

@@ hdl/qrp_in_if.sv @@
interface qrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ hdl/qrp_out_if.sv @@
interface qrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [3:0]  valid_bits;
  logic        bad_char;
  logic        too_long;
  logic [14:0] total_bits;
  logic        end_of_run;

  modport source (
    output valid, output data_byte, output valid_bits, output bad_char,
    output too_long, output total_bits, output end_of_run, input ready
  );
  modport sink (
    input valid, input data_byte, input valid_bits, input bad_char,
    input too_long, input total_bits, input end_of_run, output ready
  );
endinterface

@@ hdl/qr_segment_data_packer_top.sv @@
// channel   | dir | payload                                            | handshake
// in_ch     | in  | char_code[7:0], last_char                          | valid/ready
// out_ch    | out | data_byte, valid_bits, bad_char, too_long,         | valid/ready
//           |     | total_bits[14:0], end_of_run                       |
// cfg       | in  | cfg_wdata[1:0] (segment mode)                      | cfg_we
//
// One character per cycle while the result bank keeps pace: an accepted character
// sits in the input register, is packed and leaves 0 to 3 results in a three-entry bank.
// The bank drains one result per cycle while out_ch.ready is high; a character that
// yields several results holds the next one until the last of them is taken.
// Reset (rst_n low, synchronous) clears the mode, the packing state and both stages.
// A stall on out_ch holds the bank, then the input register, then in_ch.ready.
module qr_segment_data_packer_top (
  input  logic       clk,
  input  logic       rst_n,
  qrp_in_if.sink     in_ch,
  qrp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import qrp_pkg::*;

  logic [1:0]  mode_r;
  logic        stg_vld_r;
  logic [7:0]  stg_char_r;
  logic        stg_last_r;

  logic [10:0] grp_val_r, grp_val_nxt;
  logic [1:0]  grp_cnt_r, grp_cnt_nxt;
  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [14:0] bit_total_r, bit_total_nxt;
  logic        ovf_r, ovf_nxt;

  res_t        res_r [3];
  res_t        res_nxt [3];
  logic [1:0]  res_cnt_r, res_cnt_nxt;
  logic [1:0]  res_idx_r;

  logic        bank_free;
  logic        proc;
  logic        bad;
  logic [10:0] wr_val;
  logic [3:0]  wr_len;
  logic [10:0] gv_n;
  logic [1:0]  gc_n;
  logic [14:0] num_prod;
  logic [16:0] al_prod;
  logic [5:0]  alv;
  logic [10:0] val_m;
  logic [17:0] acc;
  logic [4:0]  cnt;
  logic [17:0] sh0;
  logic [17:0] sh1;
  logic [2:0]  rem;
  logic [6:0]  pend_n;
  logic [15:0] tot_sum;
  logic [14:0] tot_n;
  logic        ovf_n;
  logic [14:0] fin_sh;
  logic [1:0]  n;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NUMERIC;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // handshake between input register and result bank
  assign out_ch.valid = (res_idx_r != res_cnt_r);
  assign bank_free    = !out_ch.valid || (out_ch.ready && (res_idx_r + 2'd1 == res_cnt_r));
  assign proc         = stg_vld_r && bank_free;
  assign in_ch.ready  = !stg_vld_r || proc;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stg_vld_r <= 1'b1;
    end else if (proc) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_char_r <= in_ch.char_code;
      stg_last_r <= in_ch.last_char;
    end
  end

  // group building and choice of the one field written this item
  assign alv      = alnum_value(stg_char_r);
  assign num_prod = 15'(grp_val_r) * 15'd10 + 15'(stg_char_r[3:0]);
  assign al_prod  = 17'(grp_val_r) * 17'(ALNUM_COUNT) + 17'(alv);

  always_comb begin
    bad    = 1'b0;
    wr_val = '0;
    wr_len = '0;
    gv_n   = grp_val_r;
    gc_n   = grp_cnt_r;
    unique case (mode_r)
      MODE_NUMERIC: begin
        if (stg_char_r >= 8'h30 && stg_char_r <= 8'h39) begin
          gv_n = num_prod[10:0];
          gc_n = grp_cnt_r + 2'd1;
          if (gc_n == NUM_GROUP_SIZE) begin
            wr_val = gv_n;
            wr_len = NUM_TRIPLE_BITS;
            gv_n   = '0;
            gc_n   = '0;
          end
        end else begin
          bad = 1'b1;
        end
      end
      MODE_ALNUM: begin
        if (alv < ALNUM_COUNT) begin
          if (grp_cnt_r != 2'd0) begin
            wr_val = al_prod[10:0];
            wr_len = ALNUM_PAIR_BITS;
            gv_n   = '0;
            gc_n   = '0;
          end else begin
            gv_n = 11'(alv);
            gc_n = 2'd1;
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        wr_val = 11'(stg_char_r);
        wr_len = BYTE_BITS;
      end
    endcase
    // flush of an open group on the last character
    if (stg_last_r && gc_n != 2'd0 && !mode_r[1]) begin
      wr_val = gv_n;
      if (mode_r == MODE_NUMERIC) begin
        wr_len = 4'(gc_n) * 4'd3 + 4'd1;
      end else begin
        wr_len = ALNUM_SINGLE_BITS;
      end
    end
  end

  // bit packer: append field, split off full bytes
  assign val_m   = wr_val & ~(11'h7FF << wr_len);
  assign acc     = (18'(pend_bits_r) << wr_len) | 18'(val_m);
  assign cnt     = 5'(pend_cnt_r) + 5'(wr_len);
  assign sh0     = acc >> (cnt - 5'd8);
  assign sh1     = acc >> (cnt - 5'd16);
  assign rem     = cnt[2:0];
  assign pend_n  = acc[6:0] & ~(7'h7F << rem);
  assign tot_sum = 16'(bit_total_r) + 16'(wr_len);
  assign tot_n   = tot_sum[15] ? TOTAL_MAX : tot_sum[14:0];
  assign ovf_n   = ovf_r || tot_sum[15];
  assign fin_sh  = {pend_n, 8'd0} >> rem;

  // result list in delivery order
  always_comb begin
    n = '0;
    for (int i = 0; i < 3; i++) begin
      res_nxt[i] = '0;
    end
    if (bad) begin
      res_nxt[n].bad_char = 1'b1;
      res_nxt[n].too_long = ovf_r;
      n = n + 2'd1;
    end
    if (cnt >= 5'd8) begin
      res_nxt[n].data_byte  = sh0[7:0];
      res_nxt[n].valid_bits = FULL_BYTE;
      res_nxt[n].too_long   = ovf_r;
      n = n + 2'd1;
    end
    if (cnt >= 5'd16) begin
      res_nxt[n].data_byte  = sh1[7:0];
      res_nxt[n].valid_bits = FULL_BYTE;
      res_nxt[n].too_long   = ovf_r;
      n = n + 2'd1;
    end
    if (stg_last_r) begin
      res_nxt[n].data_byte  = fin_sh[7:0];
      res_nxt[n].valid_bits = 4'(rem);
      res_nxt[n].too_long   = ovf_n;
      res_nxt[n].total_bits = tot_n;
      res_nxt[n].end_of_run = 1'b1;
      n = n + 2'd1;
    end
    res_cnt_nxt = n;
  end

  // next packing state, cleared at the end of a segment
  always_comb begin
    if (stg_last_r) begin
      grp_val_nxt   = '0;
      grp_cnt_nxt   = '0;
      pend_bits_nxt = '0;
      pend_cnt_nxt  = '0;
      bit_total_nxt = '0;
      ovf_nxt       = 1'b0;
    end else begin
      grp_val_nxt   = gv_n;
      grp_cnt_nxt   = gc_n;
      pend_bits_nxt = pend_n;
      pend_cnt_nxt  = rem;
      bit_total_nxt = tot_n;
      ovf_nxt       = ovf_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_val_r   <= '0;
      grp_cnt_r   <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      bit_total_r <= '0;
      ovf_r       <= 1'b0;
    end else if (proc) begin
      grp_val_r   <= grp_val_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      bit_total_r <= bit_total_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // result bank, drained one transfer per cycle while out_ch.ready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
      res_idx_r <= '0;
    end else if (proc) begin
      res_cnt_r <= res_cnt_nxt;
      res_idx_r <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      res_idx_r <= res_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  // output payload
  assign out_ch.data_byte  = res_r[res_idx_r].data_byte;
  assign out_ch.valid_bits = res_r[res_idx_r].valid_bits;
  assign out_ch.bad_char   = res_r[res_idx_r].bad_char;
  assign out_ch.too_long   = res_r[res_idx_r].too_long;
  assign out_ch.total_bits = res_r[res_idx_r].total_bits;
  assign out_ch.end_of_run = res_r[res_idx_r].end_of_run;

endmodule

@@ hdl/qrp_checker.sv @@
module qrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic [3:0]  valid_bits,
  input logic        bad_char,
  input logic        too_long,
  input logic [14:0] total_bits,
  input logic        end_of_run
);

  // no result shown in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(valid_bits)
      && $stable(bad_char) && $stable(too_long) && $stable(total_bits)
      && $stable(end_of_run))
    else $error("stalled result changed");

  // a result that is not final is either an error or a full byte, with no total
  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !end_of_run |-> total_bits == 15'd0
      && ((bad_char && valid_bits == 4'd0 && data_byte == 8'd0)
        || (!bad_char && valid_bits == 4'd8)))
    else $error("malformed intermediate result");

  // the final result carries a partial byte with zero low bits
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_run |-> !bad_char && valid_bits <= 4'd7
      && (data_byte & (8'hFF >> valid_bits)) == 8'd0)
    else $error("malformed final result");

endmodule

bind qr_segment_data_packer_top qrp_checker u_qrp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .data_byte  (out_ch.data_byte),
  .valid_bits (out_ch.valid_bits),
  .bad_char   (out_ch.bad_char),
  .too_long   (out_ch.too_long),
  .total_bits (out_ch.total_bits),
  .end_of_run (out_ch.end_of_run)
);
